@@ design/frame_rectangle_horizontal_shift_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frame rectangle shifter
// Short forms for the clocked implication checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef FRAME_RECTANGLE_HORIZONTAL_SHIFT_MACROS_SVH
`define FRAME_RECTANGLE_HORIZONTAL_SHIFT_MACROS_SVH

// Same-cycle implication, muted during reset
`define FRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frs check failed: same-cycle implication");

// Next-cycle implication, muted during reset
`define FRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frs check failed: next-cycle implication");

`endif

@@ design/frs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_pkg
// Geometry, field widths, codes and control structs of the rectangle shifter.
// ----------------------------------------------------------------------------
package frs_pkg;

   // Frame geometry
   localparam int LINE_PITCH = 256;
   localparam int LINE_COUNT = 256;

   // Wide enough for any edge or sum (values up to 8191)
   localparam int SPAN_W = 13;

   localparam int XW     = $clog2(LINE_PITCH);
   localparam int YW     = $clog2(LINE_COUNT);
   localparam int ADDR_W = $clog2(LINE_PITCH * LINE_COUNT);
   localparam int DEPTH  = LINE_PITCH * LINE_COUNT;

   // Word field widths
   localparam int KIND_W = 2;
   localparam int COL_W  = 8;
   localparam int ROW_W  = 8;
   localparam int EDGE_W = 9;
   localparam int AMT_W  = 8;
   localparam int DATA_W = 8;
   localparam int STAT_W = 2;

   // Request kinds
   localparam logic [KIND_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] REQ_READ  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_SHIFT = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_CLIP  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   // Result source select
   localparam logic [1:0] SEL_ZERO  = 2'd0;
   localparam logic [1:0] SEL_READ  = 2'd1;
   localparam logic [1:0] SEL_EMPTY = 2'd2;
   localparam logic [1:0] SEL_SHIFT = 2'd3;

   typedef struct packed {
      logic       req_write;
      logic       req_read;
      logic       shift_load;
      logic       shift_step;
      logic       rsp_load;
      logic [1:0] rsp_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;    // rectangle empty or inverted
      logic no_work;  // nothing inside the store to move
      logic last;     // current step is the final byte
   } dp_sts_type;

   // Byte address of column x on line y
   function automatic logic [ADDR_W-1:0] addr_of(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y);
      return ADDR_W'(y) * ADDR_W'(LINE_PITCH) + ADDR_W'(x);
   endfunction

endpackage

@@ design/frs_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_req_if
// Request channel: valid/ready handshake with one request word.
// ----------------------------------------------------------------------------
interface frs_req_if import frs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] req_type;
   logic [COL_W-1:0]  col;
   logic [ROW_W-1:0]  row;
   logic [EDGE_W-1:0] col_end;
   logic [EDGE_W-1:0] row_end;
   logic [AMT_W-1:0]  amount;
   logic              toward_right;
   logic [DATA_W-1:0] wr_data;

   modport source (output valid, req_type, col, row, col_end, row_end, amount,
                   toward_right, wr_data, input ready);
   modport sink (input valid, req_type, col, row, col_end, row_end, amount,
                 toward_right, wr_data, output ready);
endinterface

@@ design/frs_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_rsp_if
// Response channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface frs_rsp_if import frs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] rd_data;
   logic [STAT_W-1:0] status;

   modport source (output valid, rd_data, status, input ready);
   modport sink (input valid, rd_data, status, output ready);
endinterface

@@ design/frs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_ctrl
// Request sequencer: decodes each request word and steps the datapath.
// ----------------------------------------------------------------------------
module frs_ctrl import frs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_type,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dp_cmd_type        cmd,
   input  dp_sts_type        sts
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DRAIN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // Take a word only when the result register is free by the next edge
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_sel = SEL_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_WRITE: begin
                     cmd.req_write = 1'b1;
                     cmd.rsp_load  = 1'b1;
                  end
                  REQ_READ: begin
                     cmd.req_read = 1'b1;
                     state_in     = S_READ;
                  end
                  REQ_SHIFT: begin
                     if (sts.empty) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_sel  = SEL_EMPTY;
                     end else begin
                        cmd.shift_load = 1'b1;
                        state_in       = sts.no_work ? S_DRAIN : S_SHIFT;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = SEL_READ;
            state_in     = S_IDLE;
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (sts.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = SEL_SHIFT;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/frs_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_dpath
// Frame store, shift cursors, one-deep copy pipeline and result register.
// ----------------------------------------------------------------------------
module frs_dpath import frs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  logic [COL_W-1:0]  col,
   input  logic [ROW_W-1:0]  row,
   input  logic [EDGE_W-1:0] col_end,
   input  logic [EDGE_W-1:0] row_end,
   input  logic [AMT_W-1:0]  amount,
   input  logic              toward_right,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data,
   output logic [STAT_W-1:0] status
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   logic [SPAN_W-1:0] col_w, row_w, ce_w, re_w, cs_w, rs_w;
   logic              clip0, in_frame;
   logic [ADDR_W-1:0] req_addr;

   // Shift cursors and bounds
   logic [XW-1:0]     col0_ff, xlast_ff, x_ff, x_in;
   logic [YW-1:0]     y_ff, y_in, ylast_ff;
   logic [AMT_W-1:0]  amt_ff;
   logic              right_ff, clip_ff, clip_in;

   // Copy pipeline
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [DATA_W-1:0] rdata_ff;
   logic              rd_ok_ff;

   logic [SPAN_W-1:0] dst_w;
   logic              dst_ok, row_done;
   logic [XW-1:0]     dst_x;
   logic [ADDR_W-1:0] src_addr, rd_addr;
   logic              rd_en;

   logic [DATA_W-1:0] rd_data_ff;
   logic [STAT_W-1:0] status_ff;

   // Request decode: bounds, clipping and empty checks
   always_comb begin
      col_w    = SPAN_W'(col);
      row_w    = SPAN_W'(row);
      ce_w     = SPAN_W'(col_end);
      re_w     = SPAN_W'(row_end);
      cs_w     = (ce_w > SPAN_W'(LINE_PITCH)) ? SPAN_W'(LINE_PITCH) : ce_w;
      rs_w     = (re_w > SPAN_W'(LINE_COUNT)) ? SPAN_W'(LINE_COUNT) : re_w;
      clip0    = (ce_w > SPAN_W'(LINE_PITCH)) || (re_w > SPAN_W'(LINE_COUNT));
      in_frame = (col_w < SPAN_W'(LINE_PITCH)) && (row_w < SPAN_W'(LINE_COUNT));
      req_addr = addr_of(XW'(col), YW'(row));
   end

   assign sts.empty   = (ce_w <= col_w) || (re_w <= row_w);
   assign sts.no_work = (col_w >= cs_w) || (row_w >= rs_w);

   // Current step: destination column and end of line/rectangle
   always_comb begin
      if (right_ff) begin
         dst_w  = SPAN_W'(x_ff) + SPAN_W'(amt_ff);
         dst_ok = dst_w < SPAN_W'(LINE_PITCH);
      end else begin
         dst_w  = SPAN_W'(x_ff) - SPAN_W'(amt_ff);
         dst_ok = SPAN_W'(x_ff) >= SPAN_W'(amt_ff);
      end
      dst_x    = dst_w[XW-1:0];
      row_done = right_ff ? (x_ff == col0_ff) : (x_ff == xlast_ff);
      src_addr = addr_of(x_ff, y_ff);
   end

   assign sts.last = row_done && (y_ff == ylast_ff);

   // Cursor, clip flag and pending write next values
   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      clip_in      = clip_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      if (cmd.shift_load) begin
         x_in    = toward_right ? XW'(cs_w - SPAN_W'(1)) : XW'(col);
         y_in    = YW'(row);
         clip_in = clip0;
      end else if (cmd.shift_step) begin
         if (dst_ok) begin
            pend_in      = 1'b1;
            pend_addr_in = addr_of(dst_x, y_ff);
         end else begin
            clip_in = 1'b1;
         end
         if (row_done) begin
            y_in = y_ff + YW'(1);
            x_in = right_ff ? xlast_ff : col0_ff;
         end else begin
            x_in = right_ff ? (x_ff - XW'(1)) : (x_ff + XW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift_load) begin
         col0_ff  <= XW'(col);
         xlast_ff <= XW'(cs_w - SPAN_W'(1));
         ylast_ff <= YW'(rs_w - SPAN_W'(1));
         amt_ff   <= amount;
         right_ff <= toward_right;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      clip_ff      <= clip_in;
      pend_addr_ff <= pend_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Frame store: one write, one registered read per cycle
   assign rd_addr = cmd.shift_step ? src_addr : req_addr;
   assign rd_en   = (cmd.shift_step && dst_ok) || (cmd.req_read && in_frame);

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         mem_ff[pend_addr_ff] <= rdata_ff;
      end else if (cmd.req_write && in_frame) begin
         mem_ff[req_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
      if (cmd.req_read) begin
         rd_ok_ff <= in_frame;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (cmd.rsp_sel)
            SEL_READ: begin
               rd_data_ff <= rd_ok_ff ? rdata_ff : '0;
               status_ff  <= ST_DONE;
            end
            SEL_EMPTY: begin
               rd_data_ff <= '0;
               status_ff  <= ST_EMPTY;
            end
            SEL_SHIFT: begin
               rd_data_ff <= '0;
               status_ff  <= clip_ff ? ST_CLIP : ST_DONE;
            end
            default: begin
               rd_data_ff <= '0;
               status_ff  <= ST_DONE;
            end
         endcase
      end
   end

   assign rd_data = rd_data_ff;
   assign status  = status_ff;

endmodule

@@ design/frame_rectangle_horizontal_shift.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rectangle_horizontal_shift
// Byte frame store with byte read/write and overlapping rectangle shift.
// ----------------------------------------------------------------------------
// One request word is handled at a time and gives one response word. A write
// or an empty or inverted rectangle loads its response as it is taken, a read
// after the registered store read. A shift loads its cursors, steps through
// every byte position of the clipped rectangle, clipped ones included, then
// loads its response. The frame store does one read and one write per cycle:
// each byte is read into a register and written in the next cycle, while the
// next byte is read. Lines are copied from the far end so overlapping bytes
// are moved before being overwritten. The store is not cleared at reset and
// must be written before it is read. A new request is taken while the
// previous response still waits, as long as it is taken that cycle.
// ----------------------------------------------------------------------------
`include "frame_rectangle_horizontal_shift_macros.svh"

module frame_rectangle_horizontal_shift import frs_pkg::*; (
   input logic       clock,
   input logic       reset,
   frs_req_if.sink   req_bus,
   frs_rsp_if.source rsp_bus
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   frs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_type  (req_bus.req_type),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   frs_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .col          (req_bus.col),
      .row          (req_bus.row),
      .col_end      (req_bus.col_end),
      .row_end      (req_bus.row_end),
      .amount       (req_bus.amount),
      .toward_right (req_bus.toward_right),
      .wr_data      (req_bus.wr_data),
      .rd_data      (rsp_bus.rd_data),
      .status       (rsp_bus.status)
   );

   // A new result never overwrites one still waiting
   `FRS_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.rsp_load, !rsp_bus.valid || rsp_bus.ready)

   // No request is taken while a shift is stepping
   `FRS_ASSERT_IMP(a_busy_shift, clock, reset, cmd.shift_step, !req_bus.ready)

   // Final shift step is followed by the response load
   `FRS_ASSERT_NEXT(a_shift_ends, clock, reset, cmd.shift_step && sts.last, cmd.rsp_load)

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte frame store with rectangle shift.
// A few line segments are seeded with byte writes first so that every read
// of the directed cases hits a known byte; the stimulus side tracks which
// bytes hold written data (shifts carry that along) and only reads those.
// Directed byte accesses and shifts follow (empty and inverted rectangles,
// zero amount, overlap in both directions, clipping at either line end,
// rectangles past the store, a full-frame shift), then random traffic in
// several idle and stall phases and one long response hold-off. A scoreboard
// keeps its own copy of the frame, predicts each response word at request
// acceptance, and compares it field by field with the response words in order.
// ----------------------------------------------------------------------------
module tb import frs_pkg::*; ();

   // Request kind with no function in the block
   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

   // Cycles without any handshake before the run is called hung
   localparam int STALL_LIMIT = 300000;
   localparam int TAIL_CYCLES = 20;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [EDGE_W-1:0] col_end;
      logic [EDGE_W-1:0] row_end;
      logic [AMT_W-1:0]  amount;
      logic              toward_right;
      logic [DATA_W-1:0] wr_data;
   } frame_req_type;

   typedef struct {
      logic [DATA_W-1:0] rd_data;
      logic [STAT_W-1:0] status;
   } frame_rsp_type;

   logic clock = 1'b0;
   logic reset;

   frs_req_if req_bus ();
   frs_rsp_if rsp_bus ();

   frame_rectangle_horizontal_shift dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Scoreboard state: frame copy and response words still owed
   logic [DATA_W-1:0] frame_model [DEPTH];
   frame_rsp_type     pending_rsp [$];

   // Stimulus side: bytes holding written data, in send order
   bit                frame_written [DEPTH];
   logic [COL_W-1:0]  last_wr_col = '0;
   logic [ROW_W-1:0]  last_wr_row = '0;

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int rsp_checked = 0;
   int kind_seen [4] = '{default: 0};
   int status_seen [4] = '{default: 0};
   int quiet_cycles = 0;
   logic [COL_W-1:0] last_col = '0;
   logic [ROW_W-1:0] last_row = '0;

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shift of one rectangle in the frame copy; returns the status code
   function automatic logic [STAT_W-1:0] apply_shift(int unsigned c0, int unsigned r0,
                                                     int unsigned c1, int unsigned r1,
                                                     int unsigned amt, bit right);
      bit          clipped;
      int unsigned cs, rs, x, d;
      clipped = 1'b0;
      if (c1 <= c0 || r1 <= r0) return ST_EMPTY;
      cs = c1;
      if (cs > LINE_PITCH) begin
         cs = LINE_PITCH;
         clipped = 1'b1;
      end
      rs = r1;
      if (rs > LINE_COUNT) begin
         rs = LINE_COUNT;
         clipped = 1'b1;
      end
      for (int unsigned r = r0; r < rs; r++) begin
         if (c0 >= cs) break;
         // far end first so overlapping bytes are read before overwritten
         for (int unsigned k = 0; k < cs - c0; k++) begin
            x = right ? (cs - 1 - k) : (c0 + k);
            if (right) begin
               d = x + amt;
               if (d >= LINE_PITCH) begin
                  clipped = 1'b1;
                  continue;
               end
            end else begin
               if (x < amt) begin
                  clipped = 1'b1;
                  continue;
               end
               d = x - amt;
            end
            frame_model[r * LINE_PITCH + d] = frame_model[r * LINE_PITCH + x];
         end
      end
      return clipped ? ST_CLIP : ST_DONE;
   endfunction

   // Expected response word for one accepted request word
   function automatic frame_rsp_type frame_predict(frame_req_type w);
      frame_rsp_type r;
      bit            in_frame;
      int unsigned   addr;
      r.rd_data = '0;
      r.status = ST_DONE;
      in_frame = (int'(w.col) < LINE_PITCH) && (int'(w.row) < LINE_COUNT);
      addr = int'(w.row) * LINE_PITCH + int'(w.col);
      case (w.kind)
         REQ_WRITE: begin
            if (in_frame) frame_model[addr] = w.wr_data;
         end
         REQ_READ: begin
            if (in_frame) r.rd_data = frame_model[addr];
         end
         REQ_SHIFT: begin
            r.status = apply_shift(w.col, w.row, w.col_end, w.row_end, w.amount,
                                   w.toward_right);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic bit byte_written(logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
      return frame_written[int'(r) * LINE_PITCH + int'(c)];
   endfunction

   // Written-byte marks follow each word as it is sent
   function automatic void track_word(frame_req_type w);
      int unsigned cs, rs, x, d;
      if (w.kind == REQ_WRITE) begin
         frame_written[int'(w.row) * LINE_PITCH + int'(w.col)] = 1'b1;
         last_wr_col = w.col;
         last_wr_row = w.row;
      end else if (w.kind == REQ_SHIFT && w.col_end > w.col && w.row_end > w.row) begin
         cs = (w.col_end > LINE_PITCH) ? LINE_PITCH : w.col_end;
         rs = (w.row_end > LINE_COUNT) ? LINE_COUNT : w.row_end;
         for (int unsigned r = w.row; r < rs; r++) begin
            for (int unsigned k = 0; k < cs - w.col; k++) begin
               x = w.toward_right ? (cs - 1 - k) : (int'(w.col) + k);
               if (w.toward_right) begin
                  d = x + w.amount;
                  if (d >= LINE_PITCH) continue;
               end else begin
                  if (x < w.amount) continue;
                  d = x - w.amount;
               end
               frame_written[r * LINE_PITCH + d] = frame_written[r * LINE_PITCH + x];
            end
         end
      end
   endfunction

   function automatic void report_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endfunction

   // Request and response monitor with in-order compare
   always @(posedge clock) begin : scoreboard
      frame_req_type w;
      frame_rsp_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         w.kind         = req_bus.req_type;
         w.col          = req_bus.col;
         w.row          = req_bus.row;
         w.col_end      = req_bus.col_end;
         w.row_end      = req_bus.row_end;
         w.amount       = req_bus.amount;
         w.toward_right = req_bus.toward_right;
         w.wr_data      = req_bus.wr_data;
         want = frame_predict(w);
         pending_rsp.push_back(want);
         kind_seen[w.kind]++;
         if (w.kind == REQ_SHIFT) status_seen[want.status]++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_checked++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response word", -1, rsp_bus.status);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.rd_data !== want.rd_data)
               report_mismatch("rd_data", want.rd_data, rsp_bus.rd_data);
            if (rsp_bus.status !== want.status)
               report_mismatch("status", want.status, rsp_bus.status);
         end
      end
   end

   // Response side: random stall, or a counted hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("frame_rectangle_horizontal_shift test failed");
         $finish;
      end
   end

   function automatic frame_req_type access_word(logic [KIND_W-1:0] kind, int c, int r,
                                                 int data);
      frame_req_type w;
      w = '{default: '0};
      w.kind    = kind;
      w.col     = COL_W'(c);
      w.row     = ROW_W'(r);
      w.wr_data = DATA_W'(data);
      return w;
   endfunction

   function automatic frame_req_type shift_word(int c, int r, int ce, int re, int amt,
                                                bit right);
      frame_req_type w;
      w = '{default: '0};
      w.kind         = REQ_SHIFT;
      w.col          = COL_W'(c);
      w.row          = ROW_W'(r);
      w.col_end      = EDGE_W'(ce);
      w.row_end      = EDGE_W'(re);
      w.amount       = AMT_W'(amt);
      w.toward_right = right;
      return w;
   endfunction

   // Drive one request word at the falling edge and hold it until taken
   task automatic send_word(frame_req_type w);
      track_word(w);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= w.kind;
      req_bus.col          <= w.col;
      req_bus.row          <= w.row;
      req_bus.col_end      <= w.col_end;
      req_bus.row_end      <= w.row_end;
      req_bus.amount       <= w.amount;
      req_bus.toward_right <= w.toward_right;
      req_bus.wr_data      <= w.wr_data;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Random request word, biased toward small rectangles and toward bytes
   // around the last shifted rectangle
   function automatic frame_req_type random_word();
      frame_req_type w;
      int            pick;
      int            sel;
      w.kind         = REQ_UNUSED;
      w.col          = COL_W'($urandom);
      w.row          = ROW_W'($urandom);
      w.col_end      = EDGE_W'($urandom);
      w.row_end      = EDGE_W'($urandom);
      w.amount       = AMT_W'($urandom);
      w.toward_right = 1'($urandom);
      w.wr_data      = DATA_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         w.kind = (pick < 30) ? REQ_WRITE : REQ_READ;
         if ($urandom_range(0, 99) < 55) begin
            w.col = last_col + COL_W'($urandom_range(0, 23));
            w.row = last_row + ROW_W'($urandom_range(0, 3));
         end
         // reads only of written bytes: else the last write, else a write
         if (w.kind == REQ_READ && !byte_written(w.col, w.row)) begin
            w.col = last_wr_col;
            w.row = last_wr_row;
            if (!byte_written(w.col, w.row)) w.kind = REQ_WRITE;
         end
      end else if (pick < 95) begin
         w.kind = REQ_SHIFT;
         // column span: empty or inverted, past the line, or a narrow one
         sel = $urandom_range(0, 99);
         if (sel < 8)
            w.col_end = EDGE_W'($urandom_range(0, w.col));
         else if (sel < 18)
            w.col_end = EDGE_W'($urandom_range(256, 511));
         else
            w.col_end = EDGE_W'(w.col) + EDGE_W'($urandom_range(1, 16));
         // line span: empty or inverted, past the store, or a few lines
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            w.row_end = EDGE_W'($urandom_range(0, w.row));
         end else if (sel < 14) begin
            w.row     = ROW_W'($urandom_range(248, 255));
            w.row_end = EDGE_W'($urandom_range(256, 511));
         end else begin
            w.row_end = EDGE_W'(w.row) + EDGE_W'($urandom_range(1, 4));
         end
         if ($urandom_range(0, 99) < 70) w.amount = AMT_W'($urandom_range(0, 20));
         last_col = w.col;
         last_row = w.row;
      end
      return w;
   endfunction

   // Known bytes under every directed read
   task automatic test_fill_store();
      idle_pct = 0;
      stall_pct = 0;
      for (int r = 7; r <= 8; r++)
         for (int c = 0; c < 16; c++)
            send_word(access_word(REQ_WRITE, c, r, $urandom));
      for (int c = 0; c < 8; c++)
         send_word(access_word(REQ_WRITE, c, 60, $urandom));
      for (int c = 248; c < LINE_PITCH; c++)
         send_word(access_word(REQ_WRITE, c, 128, $urandom));
   endtask

   // Corner bytes, data extremes and the unused request kind
   task automatic test_byte_access();
      frame_req_type w;
      send_word(access_word(REQ_WRITE, 0, 0, 8'h00));
      send_word(access_word(REQ_WRITE, 255, 255, 8'hFF));
      send_word(access_word(REQ_READ, 0, 0, 8'hFF));
      send_word(access_word(REQ_READ, 255, 255, 8'h00));
      w = shift_word(255, 255, 511, 511, 255, 1'b1);
      w.kind = REQ_UNUSED;
      w.wr_data = 8'hFF;
      send_word(w);
   endtask

   // Rectangle shift special cases, with reads of the moved bytes
   task automatic test_shift_cases();
      send_word(shift_word(10, 0, 10, 5, 3, 1'b1));     // empty column span
      send_word(shift_word(10, 20, 30, 10, 3, 1'b0));   // inverted line span
      send_word(shift_word(255, 0, 0, 4, 1, 1'b1));     // inverted column span
      send_word(shift_word(0, 3, 8, 5, 0, 1'b1));       // zero amount
      send_word(shift_word(4, 7, 12, 10, 1, 1'b1));     // overlapping, right
      send_word(shift_word(4, 7, 12, 10, 1, 1'b0));     // overlapping, left
      send_word(access_word(REQ_READ, 5, 7, 0));
      send_word(access_word(REQ_READ, 11, 8, 0));
      send_word(shift_word(240, 30, 256, 32, 10, 1'b1)); // clipped at right end
      send_word(shift_word(0, 40, 16, 41, 5, 1'b0));     // clipped at left end
      send_word(shift_word(0, 50, 2, 51, 255, 1'b1));    // largest amount, right
      send_word(shift_word(250, 60, 256, 61, 255, 1'b0)); // largest amount, left
      send_word(access_word(REQ_READ, 0, 60, 0));
      send_word(shift_word(128, 252, 511, 511, 3, 1'b1)); // rectangle past store
      send_word(shift_word(0, 0, 256, 256, 1, 1'b1));     // whole frame
      send_word(access_word(REQ_READ, 1, 0, 0));
      send_word(access_word(REQ_READ, 255, 128, 0));
   endtask

   task automatic test_random_traffic(int count, int send_idle, int recv_stall);
      idle_pct = send_idle;
      stall_pct = recv_stall;
      repeat (count) send_word(random_word());
   endtask

   // Responses held back long enough for the block to stop taking requests
   task automatic test_input_backpressure();
      idle_pct = 0;
      stall_pct = 0;
      hold_left = HOLD_CYCLES;
      repeat (24) send_word(random_word());
   endtask

   initial begin
      reset = 1'b1;
      foreach (frame_model[i]) frame_model[i] = '0;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = REQ_WRITE;
      req_bus.col          = '0;
      req_bus.row          = '0;
      req_bus.col_end      = '0;
      req_bus.row_end      = '0;
      req_bus.amount       = '0;
      req_bus.toward_right = 1'b0;
      req_bus.wr_data      = '0;
      rsp_bus.ready        = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fill_store();
      test_byte_access();
      test_shift_cases();
      test_random_traffic(90, 0, 0);
      test_random_traffic(90, 72, 0);
      test_random_traffic(90, 0, 72);
      test_random_traffic(90, 28, 28);
      test_input_backpressure();

      // drain: stop offering, let every owed word arrive, then a short tail
      @(negedge clock);
      req_bus.valid <= 1'b0;
      stall_pct = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d response words: %0d writes, %0d reads, %0d unused kind.",
               rsp_checked, kind_seen[REQ_WRITE], kind_seen[REQ_READ],
               kind_seen[REQ_UNUSED]);
      $display("Shifts: %0d done, %0d clipped, %0d empty or inverted; %0d mismatches.",
               status_seen[ST_DONE], status_seen[ST_CLIP], status_seen[ST_EMPTY],
               mismatch_count);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("frame_rectangle_horizontal_shift test passed");
      end else begin
         $display("frame_rectangle_horizontal_shift test failed");
      end
      $finish;
   end

endmodule
